### sv/fmpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmpf_pkg: shared types and constants of the first-match packet filter
// Rule table depth, index widths, protocol classes, word layouts, FSM states.
// ----------------------------------------------------------------------------
package fmpf_pkg;

    localparam int RULE_DEPTH = 128;
    localparam int IDX_W      = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RULE_DEPTH + 1);

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [2:0] CLS_ANY   = 3'd0;
    localparam logic [2:0] CLS_TCP   = 3'd1;
    localparam logic [2:0] CLS_UDP   = 3'd2;
    localparam logic [2:0] CLS_ICMP  = 3'd3;
    localparam logic [2:0] CLS_NEVER = 3'd4;

    localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
    localparam logic [7:0] IP_PROTO_TCP  = 8'd6;
    localparam logic [7:0] IP_PROTO_UDP  = 8'd17;

    localparam logic [15:0] MIN_PKT_LEN = 16'd20;
    localparam logic [15:0] TCP_HDR_LEN = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;

    localparam int FLAG_ACCEPT  = 0;
    localparam int FLAG_SRC_ANY = 1;
    localparam int FLAG_DST_ANY = 2;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } fmpf_state_t;

    typedef struct packed {
        logic        opcode;
        logic [6:0]  rule_index;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  protocol;
        logic [2:0]  rule_flags;
        logic [10:0] time_start;
        logic [10:0] time_end;
        logic [15:0] packet_length;
        logic [3:0]  header_words;
    } in_word_t;

    typedef struct packed {
        logic        verdict;
        logic        classified;
        logic        rule_hit;
        logic [6:0]  matched_index;
        logic [31:0] blocked_total;
        logic [31:0] accepted_total;
    } out_word_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [2:0]  code;
        logic [2:0]  flags;
        logic [10:0] t_start;
        logic [10:0] t_end;
    } rule_t;

endpackage
`default_nettype wire

### sv/first_match_packet_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_match_packet_filter: first-match ACL packet classifier
//
// Input words arrive on s_valid/s_ready with an in_word_t payload. A load word
// writes one rule into the table; a classify word scans the first
// rules_in_use rules (at most RULE_DEPTH) from entry zero, one rule per cycle
// through the single read port of the rule memory and one shared match unit.
// One result word leaves on m_valid/m_ready per input word.
// The rules_in_use register is written on cfg_valid/cfg_ready, always ready;
// write it only while the block is idle.
// Flow, with the output free: a load, a short packet or a classify word with no
// rules to scan goes from ST_IDLE to ST_FINISH; any other classify word passes
// through ST_SCAN up to the first match or the last rule in use, then ST_FINISH.
// The result is registered in ST_FINISH once the output slot is free.
// s_ready is low while a word is in work.
// The output register holds a finished result while m_ready is low; the next
// input word is taken meanwhile, and its result waits until the slot frees.
// Reset clears the counters, rules_in_use and the handshake state. The rule
// table is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module first_match_packet_filter
    import fmpf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [7:0] cfg_data
);

    fmpf_state_t state_reg, state_next;

    logic [7:0]       rules_in_use_reg;
    logic [CNT_W-1:0] limit_reg, limit_next, limit_w;
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_en;
    rule_t            rd_data_reg;

    logic [31:0] pkt_src_reg, pkt_src_next;
    logic [31:0] pkt_dst_reg, pkt_dst_next;
    logic [15:0] pkt_sport_reg, pkt_sport_next;
    logic [15:0] pkt_dport_reg, pkt_dport_next;
    logic [2:0]  pkt_cls_reg, pkt_cls_next;
    logic [10:0] pkt_minute_reg, pkt_minute_next;

    logic             res_verdict_reg, res_verdict_next;
    logic             res_classified_reg, res_classified_next;
    logic             res_hit_reg, res_hit_next;
    logic [CNT_W-1:0] res_idx_reg, res_idx_next;

    logic [31:0] blocked_count_reg, blocked_count_next;
    logic [31:0] accepted_count_reg, accepted_count_next;

    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rule_t            wr_rule;
    rule_t            rule_mem [RULE_DEPTH];

    logic        accept_in;
    logic        long_pkt;
    logic        rule_match;
    logic        out_free;
    logic [15:0] tcp_min_len;
    logic [15:0] udp_min_len;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign accept_in   = s_valid && s_ready;
    assign long_pkt    = (s_data.packet_length >= MIN_PKT_LEN);
    assign tcp_min_len = {10'd0, s_data.header_words, 2'b00} + TCP_HDR_LEN;
    assign udp_min_len = {10'd0, s_data.header_words, 2'b00} + UDP_HDR_LEN;
    assign out_free    = !m_valid_reg || m_ready;
    assign limit_w     = (32'(rules_in_use_reg) > RULE_DEPTH) ? CNT_W'(RULE_DEPTH)
                                                              : CNT_W'(rules_in_use_reg);

    assign wr_en   = accept_in && (s_data.opcode == OP_LOAD)
                     && (32'(s_data.rule_index) < RULE_DEPTH);
    assign wr_addr = IDX_W'(s_data.rule_index);

    always_comb begin
        wr_rule          = '0;
        wr_rule.src_addr = s_data.src_addr;
        wr_rule.dst_addr = s_data.dst_addr;
        wr_rule.sport    = s_data.sport;
        wr_rule.dport    = s_data.dport;
        wr_rule.code     = (s_data.protocol > 8'(CLS_NEVER)) ? CLS_NEVER
                                                             : s_data.protocol[2:0];
        wr_rule.flags    = s_data.rule_flags;
        wr_rule.t_start  = s_data.time_start;
        wr_rule.t_end    = s_data.time_end;
    end

    assign rd_en = (state_reg == ST_SCAN) && (issue_idx_reg < limit_reg);

    assign rule_match =
        (rd_data_reg.flags[FLAG_SRC_ANY] || (rd_data_reg.src_addr == pkt_src_reg)) &&
        (rd_data_reg.flags[FLAG_DST_ANY] || (rd_data_reg.dst_addr == pkt_dst_reg)) &&
        ((rd_data_reg.sport == 16'd0) || (rd_data_reg.sport == pkt_sport_reg)) &&
        ((rd_data_reg.dport == 16'd0) || (rd_data_reg.dport == pkt_dport_reg)) &&
        ((rd_data_reg.code == CLS_ANY) || (rd_data_reg.code == pkt_cls_reg)) &&
        (pkt_minute_reg >= rd_data_reg.t_start) &&
        (pkt_minute_reg <= rd_data_reg.t_end);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if ((s_data.opcode == OP_CLASSIFY) && long_pkt && (limit_w != '0)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_pend_reg
                    && (rule_match || (cmp_idx_reg == CNT_W'(limit_reg - 1'b1)))) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        limit_next          = limit_reg;
        issue_idx_next      = issue_idx_reg;
        cmp_idx_next        = cmp_idx_reg;
        rd_pend_next        = rd_pend_reg;
        pkt_src_next        = pkt_src_reg;
        pkt_dst_next        = pkt_dst_reg;
        pkt_sport_next      = pkt_sport_reg;
        pkt_dport_next      = pkt_dport_reg;
        pkt_cls_next        = pkt_cls_reg;
        pkt_minute_next     = pkt_minute_reg;
        res_verdict_next    = res_verdict_reg;
        res_classified_next = res_classified_reg;
        res_hit_next        = res_hit_reg;
        res_idx_next        = res_idx_reg;
        blocked_count_next  = blocked_count_reg;
        accepted_count_next = accepted_count_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_data_next         = m_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    limit_next          = limit_w;
                    issue_idx_next      = '0;
                    cmp_idx_next        = '0;
                    rd_pend_next        = 1'b0;
                    pkt_src_next        = s_data.src_addr;
                    pkt_dst_next        = s_data.dst_addr;
                    pkt_sport_next      = 16'd0;
                    pkt_dport_next      = 16'd0;
                    pkt_cls_next        = CLS_ANY;
                    pkt_minute_next     = s_data.time_start;
                    res_verdict_next    = 1'b1;
                    res_classified_next = (s_data.opcode == OP_CLASSIFY) && long_pkt;
                    res_hit_next        = 1'b0;
                    res_idx_next        = '0;
                    if ((s_data.protocol == IP_PROTO_TCP)
                        && (s_data.packet_length >= tcp_min_len)) begin
                        pkt_cls_next   = CLS_TCP;
                        pkt_sport_next = s_data.sport;
                        pkt_dport_next = s_data.dport;
                    end else if ((s_data.protocol == IP_PROTO_UDP)
                                 && (s_data.packet_length >= udp_min_len)) begin
                        pkt_cls_next   = CLS_UDP;
                        pkt_sport_next = s_data.sport;
                        pkt_dport_next = s_data.dport;
                    end else if (s_data.protocol == IP_PROTO_ICMP) begin
                        pkt_cls_next = CLS_ICMP;
                    end
                end
            end
            ST_SCAN: begin
                rd_pend_next = rd_en;
                if (rd_en) begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                if (rd_pend_reg) begin
                    if (rule_match) begin
                        res_hit_next     = 1'b1;
                        res_verdict_next = rd_data_reg.flags[FLAG_ACCEPT];
                        res_idx_next     = cmp_idx_reg;
                    end else begin
                        cmp_idx_next = cmp_idx_reg + 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    if (res_classified_reg) begin
                        if (!res_verdict_reg) begin
                            if (blocked_count_reg != COUNT_MAX) begin
                                blocked_count_next = blocked_count_reg + 32'd1;
                            end
                        end else begin
                            if (accepted_count_reg != COUNT_MAX) begin
                                accepted_count_next = accepted_count_reg + 32'd1;
                            end
                        end
                    end
                    m_valid_next               = 1'b1;
                    m_data_next.verdict        = res_verdict_reg;
                    m_data_next.classified     = res_classified_reg;
                    m_data_next.rule_hit       = res_hit_reg;
                    m_data_next.matched_index  = 7'(res_idx_reg);
                    m_data_next.blocked_total  = blocked_count_next;
                    m_data_next.accepted_total = accepted_count_next;
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rule_mem[wr_addr] <= wr_rule;
        end
        if (rd_en) begin
            rd_data_reg <= rule_mem[issue_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            rules_in_use_reg   <= 8'd0;
            limit_reg          <= '0;
            issue_idx_reg      <= '0;
            cmp_idx_reg        <= '0;
            rd_pend_reg        <= 1'b0;
            blocked_count_reg  <= 32'd0;
            accepted_count_reg <= 32'd0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            if (cfg_valid && cfg_ready) begin
                rules_in_use_reg <= cfg_data;
            end
            limit_reg          <= limit_next;
            issue_idx_reg      <= issue_idx_next;
            cmp_idx_reg        <= cmp_idx_next;
            rd_pend_reg        <= rd_pend_next;
            blocked_count_reg  <= blocked_count_next;
            accepted_count_reg <= accepted_count_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pkt_src_reg        <= pkt_src_next;
        pkt_dst_reg        <= pkt_dst_next;
        pkt_sport_reg      <= pkt_sport_next;
        pkt_dport_reg      <= pkt_dport_next;
        pkt_cls_reg        <= pkt_cls_next;
        pkt_minute_reg     <= pkt_minute_next;
        res_verdict_reg    <= res_verdict_next;
        res_classified_reg <= res_classified_next;
        res_hit_reg        <= res_hit_next;
        res_idx_reg        <= res_idx_next;
        m_data_reg         <= m_data_next;
    end

`ifndef SYNTHESIS
    a_drop_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.verdict |-> m_data_reg.rule_hit && m_data_reg.classified)
        else $error("drop verdict without a classified rule hit");

    a_hit_needs_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.rule_hit |-> m_data_reg.classified)
        else $error("rule hit on an unclassified word");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cmp_idx_reg < limit_reg))
        else $error("scan index beyond rule count");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (accepted_count_reg >= $past(accepted_count_reg))
                           && (blocked_count_reg >= $past(blocked_count_reg)))
        else $error("packet counter decreased");
`endif

endmodule
`default_nettype wire
